// ===== rtl/rwps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_pkg
// shared types and constants of the radius weighted point smoothing block
// ----------------------------------------------------------------------------
package rwps_pkg;

	localparam int INDEX_W  = 10;
	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int COEF_W   = 17;
	localparam int COUNT_W  = 11;
	localparam int CFG_W    = 31;
	localparam int CFG_AW   = 2;
	localparam int TDATA_W  = 112;
	localparam int POINT_W  = 3 * COORD_W;

	// integer square root unit
	localparam int SQ_W     = 64;
	localparam int ROOT_W   = 32;
	localparam int SQ_STEPS = 32;

	localparam logic [COEF_W-1:0]   COEF_ONE     = 17'd65536;
	localparam logic [RADIUS_W-1:0] RADIUS_RST   = 31'd65536;
	localparam logic [COEF_W-1:0]   COEF_RST     = 17'd32768;
	localparam logic [COUNT_W-1:0]  COUNT_RST    = 11'd0;

	localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_COEF   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_COUNT  = 2'd2;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_SCAN,
		ST_DSET,
		ST_DIV,
		ST_BL1,
		ST_BL2,
		ST_BL3,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/radius_weighted_point_smoothing.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radius_weighted_point_smoothing
// distance weighted smoothing of 3-d points held in an on-chip store
// ----------------------------------------------------------------------------
// A load transaction (tuser = 0) writes one Q16.16 point into the store
// and gives no result. A query transaction (tuser = 1) reads the
// point at index, then streams the first point_count stored points through a
// distance pipeline, one point per cycle through the single store read port,
// weighting every point closer than the radius by radius minus distance.
// The weighted sums are then divided by the total weight in a bit-serial
// divider, one axis after the other, and blended with the original point.
// Only one transaction is in work at a time; a finished result waits in the
// output register while the next transaction is taken. Store entries hold
// nothing until loaded and there is no clearing pass: a query must only
// touch loaded entries. A query for an index beyond the store returns zero
// coordinates.
// ----------------------------------------------------------------------------
module radius_weighted_point_smoothing
	import rwps_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration write port
	input  wire                 cfg_we,
	input  wire [CFG_AW-1:0]    cfg_addr,
	input  wire [CFG_W-1:0]     cfg_wdata,
	// input stream
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire [TDATA_W-1:0]   s_tdata,   // index[9:0], px[41:10], py[73:42], pz[105:74]
	input  wire                 s_tuser,   // func: 0 load, 1 query
	// result stream
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [TDATA_W-1:0]  m_tdata    // point_index[9:0], sx[41:10], sy[73:42], sz[105:74]
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int ACCW = 64 + AW;
	localparam int MW   = 31 + AW;
	localparam int DCW  = $clog2(ACCW + 1);

	// ---------------- configuration registers
	logic [RADIUS_W-1:0] radius_q;
	logic [COEF_W-1:0]   coef_q;
	logic [COUNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			coef_q   <= COEF_RST;
			count_q  <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RADIUS: radius_q <= cfg_wdata[RADIUS_W-1:0];
				CFG_COEF:   coef_q   <= cfg_wdata[COEF_W-1:0];
				CFG_COUNT:  count_q  <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped coefficient and count
	logic [COEF_W-1:0] k_eff;
	logic [COEF_W-1:0] kc_eff;
	logic [CW-1:0]     cnt_eff;

	assign k_eff   = (coef_q > COEF_ONE) ? COEF_ONE : coef_q;
	assign kc_eff  = COEF_ONE - k_eff;
	assign cnt_eff = (32'(count_q) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(count_q);

	// ---------------- input unpack
	logic              in_acc;
	logic [INDEX_W-1:0] s_idx;
	logic              s_in_range;

	assign in_acc     = s_tvalid && s_tready;
	assign s_idx      = s_tdata[INDEX_W-1:0];
	assign s_in_range = 32'(s_idx) < 32'(MAX_POINTS);

	// ---------------- control
	state_t state_q, state_d;
	logic [INDEX_W-1:0] idx_q;
	logic [CW-1:0]      j_q;
	logic [1:0]         ax_q;
	logic [DCW-1:0]     dc_q;
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;

	logic issue;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic load_out;
	logic pipe_busy;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		issue     = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = j_q[AW-1:0];
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == FUNC_QUERY) begin
					state_d = s_in_range ? ST_POS : ST_OUT;
				end
			end
			ST_POS: begin
				// fetch the queried point itself
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_q);
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				issue  = j_q < cnt_eff;
				ram_re = issue;
				if (!issue && !pipe_busy) begin
					state_d = ST_DSET;
				end
			end
			ST_DSET: state_d = ST_DIV;
			ST_DIV: begin
				if (dc_q == DCW'(1)) begin
					state_d = ST_BL1;
				end
			end
			ST_BL1: state_d = ST_BL2;
			ST_BL2: state_d = ST_BL3;
			ST_BL3: state_d = (ax_q == 2'd2) ? ST_OUT : ST_DSET;
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- point store
	logic [POINT_W-1:0] ram_rdata;
	logic               ram_we;

	assign ram_we = in_acc && s_tuser == FUNC_LOAD && s_in_range;

	rwps_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(s_idx)),
		.wdata (s_tdata[INDEX_W +: POINT_W]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- distance pipeline
	logic rv_s1, posv_s1;
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [COORD_W-1:0] pos_q [3];
	logic signed [COORD_W-1:0] pj_s1 [3];
	logic signed [COORD_W:0]   d_s2 [3];
	logic [POINT_W-1:0]        pj_s2, pj_s3, pj_s4, pj_s5, pj_s6, pj_s7;
	logic [RADIUS_W-1:0]       m_s3 [3];
	logic                      far_s3, far_s4, far_s5;
	logic [61:0]               sq_s4 [3];
	logic [SQ_W-1:0]           d2_s5, d2_s6;
	logic [61:0]               r2_q;
	logic [RADIUS_W-1:0]       w_s7, w_s8;
	logic signed [63:0]        prod_s8 [3];
	logic signed [ACCW-1:0]    acc_q [3];
	logic [MW-1:0]             mass_q;

	logic                sq_valid, sq_busy;
	logic [ROOT_W-1:0]   sq_root;
	logic [POINT_W-1:0]  sq_pay;

	for (genvar a = 0; a < 3; a++) begin : g_unpk
		assign pj_s1[a] = ram_rdata[a*COORD_W +: COORD_W];
	end

	// magnitudes and far flag of the difference vector
	logic [COORD_W:0] mag [3];
	logic             far_any;
	always_comb begin
		far_any = 1'b0;
		for (int a = 0; a < 3; a++) begin
			mag[a]  = d_s2[a][COORD_W] ? 33'(-d_s2[a]) : 33'(d_s2[a]);
			far_any = far_any | (mag[a][COORD_W:RADIUS_W] != 2'b00);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1   <= 1'b0;
			posv_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
		end else begin
			rv_s1   <= issue;
			posv_s1 <= state_q == ST_POS;
			v_s2    <= rv_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			// only points inside the radius go on to the square root
			v_s6    <= v_s5 && !far_s5 && (d2_s5 < {2'b00, r2_q});
			v_s7    <= sq_valid;
			v_s8    <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (posv_s1) begin
			for (int a = 0; a < 3; a++) begin
				pos_q[a] <= pj_s1[a];
			end
		end
		if (state_q == ST_POS) begin
			r2_q <= radius_q * radius_q;
		end
		for (int a = 0; a < 3; a++) begin
			d_s2[a]    <= {pos_q[a][COORD_W-1], pos_q[a]} - {pj_s1[a][COORD_W-1], pj_s1[a]};
			m_s3[a]    <= mag[a][RADIUS_W-1:0];
			sq_s4[a]   <= m_s3[a] * m_s3[a];
			prod_s8[a] <= $signed({1'b0, w_s7}) * $signed(pj_s7[a*COORD_W +: COORD_W]);
		end
		pj_s2  <= ram_rdata;
		pj_s3  <= pj_s2;
		pj_s4  <= pj_s3;
		pj_s5  <= pj_s4;
		pj_s6  <= pj_s5;
		far_s3 <= far_any;
		far_s4 <= far_s3;
		far_s5 <= far_s4;
		d2_s5  <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
		d2_s6  <= d2_s5;
		// root is below the radius for any point that got this far
		w_s7   <= radius_q - sq_root[RADIUS_W-1:0];
		pj_s7  <= sq_pay;
		w_s8   <= w_s7;
	end

	rwps_isqrt #(
		.PW (POINT_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_val    (d2_s6),
		.in_pay    (pj_s6),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_pay   (sq_pay),
		.busy      (sq_busy)
	);

	assign pipe_busy = rv_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | sq_busy | v_s7 | v_s8;

	// ---------------- divider and blend
	logic [ACCW-1:0]           dvd_q;
	logic                      neg_q;
	logic [MW-1:0]             rem_q;
	logic [COORD_W-1:0]        qt_q;
	logic signed [COORD_W:0]   c_q;
	logic signed [49:0]        pk_q, pp_q;
	logic [COORD_W-1:0]        res_q [3];

	logic [MW:0]         rn;
	logic                ge;
	logic [MW:0]         rdiff;
	logic signed [51:0]  t_sum;
	logic signed [35:0]  t_shr;
	logic [COORD_W-1:0]  sat;

	assign rn    = {rem_q, dvd_q[ACCW-1]};
	assign ge    = rn >= {1'b0, mass_q};
	assign rdiff = rn - {1'b0, mass_q};
	assign t_sum = 52'(pk_q) + 52'(pp_q) + 52'sd32768;
	assign t_shr = t_sum[51:16];

	always_comb begin
		if (!t_shr[35] && t_shr[35:31] != 5'h00) begin
			sat = 32'h7fff_ffff;
		end else if (t_shr[35] && t_shr[35:31] != 5'h1f) begin
			sat = 32'h8000_0000;
		end else begin
			sat = t_shr[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			ax_q       <= 2'd0;
			dc_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_POS) begin
				j_q  <= '0;
				ax_q <= 2'd0;
			end else if (issue) begin
				j_q <= j_q + CW'(1);
			end else if (state_q == ST_BL3) begin
				ax_q <= ax_q + 2'd1;
			end
			if (state_q == ST_DSET) begin
				dc_q <= DCW'(ACCW);
			end else if (state_q == ST_DIV) begin
				dc_q <= dc_q - DCW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q <= s_idx;
			if (!s_in_range) begin
				for (int a = 0; a < 3; a++) begin
					res_q[a] <= '0;
				end
			end
		end
		// accumulation of weights and weighted coordinates
		if (state_q == ST_POS) begin
			mass_q <= '0;
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= '0;
			end
		end else if (v_s8) begin
			mass_q <= mass_q + MW'(w_s8);
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= acc_q[a] + ACCW'(prod_s8[a]);
			end
		end
		case (state_q)
			ST_DSET: begin
				neg_q <= acc_q[ax_q][ACCW-1];
				dvd_q <= acc_q[ax_q][ACCW-1] ? ACCW'(-acc_q[ax_q]) : ACCW'(acc_q[ax_q]);
				rem_q <= '0;
				qt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? rdiff[MW-1:0] : rn[MW-1:0];
				dvd_q <= dvd_q << 1;
				qt_q  <= {qt_q[COORD_W-2:0], ge};
			end
			ST_BL1: begin
				if (mass_q == '0) begin
					c_q <= '0;
				end else begin
					c_q <= neg_q ? -$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
				end
			end
			ST_BL2: begin
				pk_q <= 50'($signed({1'b0, kc_eff}) * c_q);
				pp_q <= 50'($signed({1'b0, k_eff}) * pos_q[ax_q]);
			end
			ST_BL3: res_q[ax_q] <= sat;
			default: ;
		endcase
		if (load_out) begin
			m_tdata_q <= {6'd0, res_q[2], res_q[1], res_q[0], idx_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// no new transaction while points are still in the distance pipeline
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pipe_busy)
		else $error("transaction taken while scan pipeline busy");

	// a point inside the radius always carries a nonzero weight
	a_weight_nz: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> w_s7 != '0)
		else $error("zero weight for a point inside the radius");

	// accumulation only happens during the scan
	a_acc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> state_q == ST_SCAN)
		else $error("accumulation outside of scan");

	// divider never runs with an exhausted bit counter
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dc_q != '0)
		else $error("divider bit counter underflow");
`endif

endmodule
`default_nettype wire

// ===== rtl/rwps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rwps_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rwps_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_isqrt
// pipelined integer square root, one result bit per stage, with side payload
// ----------------------------------------------------------------------------
module rwps_isqrt
	import rwps_pkg::*;
#(
	parameter int PW = 96
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire [SQ_W-1:0]     in_val,
	input  wire [PW-1:0]       in_pay,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  out_root,
	output logic [PW-1:0]      out_pay,
	output logic               busy
);

	logic [SQ_STEPS-1:0] v_q;
	logic [SQ_W-1:0]     rem_q [SQ_STEPS];
	logic [SQ_W-1:0]     res_q [SQ_STEPS];
	logic [PW-1:0]       pay_q [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic            v_in;
		logic [SQ_W-1:0] rem_in;
		logic [SQ_W-1:0] res_in;
		logic [PW-1:0]   pay_in;
		logic [SQ_W-1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = in_val;
			assign res_in = '0;
			assign pay_in = in_pay;
		end else begin : g_next
			assign v_in   = v_q[k-1];
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
			assign pay_in = pay_q[k-1];
		end

		assign trial = res_in + BIT;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k] <= take ? rem_in - trial : rem_in;
			res_q[k] <= take ? (res_in >> 1) + BIT : res_in >> 1;
			pay_q[k] <= pay_in;
		end
	end

	assign out_valid = v_q[SQ_STEPS-1];
	assign out_root  = res_q[SQ_STEPS-1][ROOT_W-1:0];
	assign out_pay   = pay_q[SQ_STEPS-1];
	assign busy      = |v_q;

endmodule
`default_nettype wire

// ===== tb/tb_radius_weighted_point_smoothing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radius_weighted_point_smoothing
// stream testbench for the radius weighted point smoothing block
// ----------------------------------------------------------------------------
// Point loads and queries are queued by a stimulus process and sent by a
// clocked driver. A clocked monitor takes each result transaction and checks
// it against a smoothing predictor that runs in the testbench. The predictor
// keeps its own copy of the point store and of the registers. Registers are
// written only while the block is idle, and each setting forms one phase.
// ----------------------------------------------------------------------------
module tb_radius_weighted_point_smoothing;
	import rwps_pkg::*;

	localparam int NPTS  = 1024;
	localparam int NLOAD = 64;

	typedef struct packed {
		logic               func;
		logic [INDEX_W-1:0] idx;
		logic [31:0]        x, y, z;
	} point_op_t;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [31:0]        x, y, z;
	} smooth_pt_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;  // index, px, py, pz
	logic                s_tuser = 1'b0; // func
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;       // point_index, sx, sy, sz

	radius_weighted_point_smoothing DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic signed [31:0] model_pts [NPTS][3];
	bit                 loaded [NPTS];
	logic [30:0]        model_radius = RADIUS_RST;
	logic [16:0]        model_coef = COEF_RST;
	logic [10:0]        model_count = COUNT_RST;

	point_op_t  pending_ops [$];
	smooth_pt_t expected_pts [$];
	int         n_errors = 0;
	bit         send_done = 1'b0;
	bit         quiet = 1'b0; // no random gaps while set

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// weighted centroid of the neighborhood, blended with the point itself
	function automatic smooth_pt_t smooth_point(logic [INDEX_W-1:0] i);
		smooth_pt_t         res;
		logic signed [63:0] pos [3];
		logic signed [127:0] acc [3];
		logic signed [127:0] c, t, q;
		logic [63:0]        mass, r2, d2, m, w;
		logic signed [63:0] d;
		logic signed [63:0] k;
		int                 cnt;
		bit                 far;
		res.idx = i;
		mass = 0;
		r2 = 64'(model_radius) * 64'(model_radius);
		k = (model_coef > COEF_ONE) ? 64'sd65536 : 64'(model_coef);
		cnt = (model_count > NPTS) ? NPTS : model_count;
		for (int a = 0; a < 3; a++) begin
			pos[a] = model_pts[i][a];
			acc[a] = 0;
		end
		for (int j = 0; j < cnt; j++) begin
			d2 = 0;
			far = 0;
			for (int a = 0; a < 3; a++) begin
				d = pos[a] - 64'(model_pts[j][a]);
				m = (d < 0) ? -d : d;
				if (m >= 64'h8000_0000) far = 1;
				else d2 += m * m;
			end
			if (far || d2 >= r2) continue;
			w = 64'(model_radius) - int_sqrt(d2);
			mass += w;
			for (int a = 0; a < 3; a++)
				acc[a] += $signed({64'd0, w}) * 128'(model_pts[j][a]);
		end
		for (int a = 0; a < 3; a++) begin
			// division truncates toward zero, quotient kept to 40 bits
			if (mass != 0) begin
				c = (acc[a] < 0) ? -acc[a] : acc[a];
				c = c / $signed({64'd0, mass});
				c = c & 128'hFF_FFFF_FFFF;
				if (acc[a] < 0) c = -c;
			end else begin
				c = 0;
			end
			t = (128'(65536) - k) * c + 128'(k) * 128'(pos[a]) + 128'sd32768;
			q = t >>> 16;
			if (q > 128'sd2147483647) q = 128'sd2147483647;
			if (q < -128'sd2147483648) q = -128'sd2147483648;
			if (a == 0) res.x = q[31:0];
			else if (a == 1) res.y = q[31:0];
			else res.z = q[31:0];
		end
		if (i >= NPTS) begin
			res.x = 0;
			res.y = 0;
			res.z = 0;
		end
		return res;
	endfunction

	// driver: one transaction per queued item with a random gap before each
	int gap_in = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				gap_in = quiet ? 0 : $urandom_range(0, 8);
				if (gap_in == 0 && pending_ops.size() > 0) begin
					s_tuser <= pending_ops[0].func;
					s_tdata <= {6'd0, pending_ops[0].z, pending_ops[0].y,
						pending_ops[0].x, pending_ops[0].idx};
					pending_ops.delete(0);
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (!s_tvalid) begin
				if (gap_in > 0) begin
					gap_in--;
				end else if (pending_ops.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_ops[0].func;
					s_tdata <= {6'd0, pending_ops[0].z, pending_ops[0].y,
						pending_ops[0].x, pending_ops[0].idx};
					pending_ops.delete(0);
					gap_in = quiet ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	// monitor: random stalls on the result side, check against expectations
	int stall_out = 0;
	always @(posedge clk) begin
		smooth_pt_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.idx = m_tdata[9:0];
				got.x   = m_tdata[41:10];
				got.y   = m_tdata[73:42];
				got.z   = m_tdata[105:74];
				if (expected_pts.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result idx=%0d", got.idx);
				end else begin
					want = expected_pts[0];
					expected_pts.delete(0);
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch exp idx %0d x %h y %h z %h got idx %0d x %h y %h z %h",
								want.idx, want.x, want.y, want.z,
								got.idx, got.x, got.y, got.z);
					end
				end
				stall_out = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0) stall_out = 0;
			end
			if (stall_out > 0) begin
				stall_out--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// predict at the moment of queueing; order of queue equals order of sending
	task automatic push_op(logic f, logic [INDEX_W-1:0] i,
		logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_op_t op;
		op = '{f, i, x, y, z};
		pending_ops.insert(pending_ops.size(), op);
		if (f == FUNC_LOAD) begin
			model_pts[i][0] = x;
			model_pts[i][1] = y;
			model_pts[i][2] = z;
			loaded[i] = 1;
		end else begin
			expected_pts.insert(expected_pts.size(), smooth_point(i));
		end
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || s_tvalid || expected_pts.size() > 0)
			@(posedge clk);
		// a trailing load may still be in work
		repeat (1400) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] a, logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (a == CFG_RADIUS) model_radius = v;
		else if (a == CFG_COEF) model_coef = v[16:0];
		else model_count = v[10:0];
	endtask

	function automatic logic [31:0] rand_coord(int spread);
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	// query only loaded points; count stays within loaded prefix
	task automatic random_phase(int n_ops, int n_pts, int spread);
		int i;
		for (int k = 0; k < n_ops; k++) begin
			if ($urandom_range(0, 2) == 0) begin
				i = $urandom_range(0, n_pts - 1);
				push_op(FUNC_LOAD, i, rand_coord(spread), rand_coord(spread),
					rand_coord(spread));
			end else begin
				i = $urandom_range(0, n_pts - 1);
				if ($urandom_range(0, 9) == 0) i = $urandom_range(NPTS, 1023);
				push_op(FUNC_QUERY, i, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		int np;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: loads with extreme coordinates, then a query at reset settings
		push_op(FUNC_LOAD, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_op(FUNC_LOAD, 1, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_1000);
		push_op(FUNC_LOAD, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_op(FUNC_LOAD, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(FUNC_LOAD, 1023, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
		push_op(FUNC_QUERY, 0, 0, 0, 0); // count zero: no neighbors
		drain();
		write_reg(CFG_COUNT, 4);
		push_op(FUNC_QUERY, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(FUNC_QUERY, 1, 0, 0, 0);
		push_op(FUNC_QUERY, 2, 0, 0, 0);
		push_op(FUNC_QUERY, 3, 0, 0, 0);
		push_op(FUNC_QUERY, 1023, 0, 0, 0); // index beyond count
		drain();
		write_reg(CFG_RADIUS, 0); // zero radius
		write_reg(CFG_COEF, 17'h1FFFF); // coefficient above one
		push_op(FUNC_QUERY, 2, 0, 0, 0);
		push_op(FUNC_QUERY, 1, 0, 0, 0);
		drain();
		write_reg(CFG_RADIUS, 31'h7FFF_FFFF);
		write_reg(CFG_COEF, 0);
		write_reg(CFG_COUNT, NLOAD);
		for (int i = 4; i < NLOAD; i++)
			push_op(FUNC_LOAD, i, $urandom, $urandom, $urandom);
		push_op(FUNC_QUERY, 2, 0, 0, 0);
		push_op(FUNC_QUERY, 1, 0, 0, 0);
		drain();
		// random phases over several settings; small counts keep queries short
		for (int ph = 0; ph < 8; ph++) begin
			np = $urandom_range(2, NLOAD);
			write_reg(CFG_RADIUS, (ph % 3 == 0) ? $urandom_range(0, 31'h7FFF_FFFF)
				: $urandom_range(1, 32'h0004_0000));
			write_reg(CFG_COEF, (ph == 1) ? COEF_ONE : $urandom_range(0, 65536));
			write_reg(CFG_COUNT, np);
			quiet = (ph == 3);
			random_phase(63, np, (ph % 2) ? 32'h0002_0000 : 32'h4000_0000);
			drain();
		end
		quiet = 0;
		send_done = 1;
		if (n_errors == 0 && expected_pts.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
